FILE: rtl/core/owfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package owfc_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_NO_DEV  = 2'd2;

    // Input item kinds
    localparam logic KIND_BUS_RESET = 1'b0;
    localparam logic KIND_DATA      = 1'b1;

    // Frame types
    localparam logic FRAME_SCRATCH = 1'b0;
    localparam logic FRAME_ROM     = 1'b1;

    // Configuration register indexes
    localparam logic CFG_RESOLUTION  = 1'b0;
    localparam logic CFG_FAMILY_CODE = 1'b1;

    // Resolution codes
    localparam logic [1:0] RES_9BIT  = 2'd0;
    localparam logic [1:0] RES_10BIT = 2'd1;
    localparam logic [1:0] RES_11BIT = 2'd2;
    localparam logic [1:0] RES_12BIT = 2'd3;

    localparam logic [1:0] RESOLUTION_RESET  = RES_12BIT;
    localparam logic [7:0] FAMILY_CODE_RESET = 8'd40;

    // Frame lengths in bytes, final byte is the CRC
    localparam logic [3:0] SCRATCH_LEN = 4'd9;
    localparam logic [3:0] ROM_LEN     = 4'd8;

    // Reflected CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef struct packed {
        logic [1:0]         status;
        logic               frame_type;
        logic signed [15:0] temperature;
        logic [47:0]        serial_number;
    } result_t;

    // One byte through the reflected CRC-8, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc_in;
        d = data;
        for (int k = 0; k < 8; k++)
        begin
            if ((c[0] ^ d[0]) == 1'b1)
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    // Clear the undefined low bits for the given resolution
    function automatic logic [15:0] res_mask(input logic [1:0] res);
        logic [15:0] m;
        case (res)
            RES_9BIT:  m = 16'hFFF8;
            RES_10BIT: m = 16'hFFFC;
            RES_11BIT: m = 16'hFFFE;
            default:   m = 16'hFFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/owfc_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none

module owfc_frame_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic             kind,
    input  wire logic             presence,
    input  wire logic             frame_type,
    input  wire logic [7:0]       data_byte,
    input  wire logic [1:0]       resolution,
    input  wire logic [7:0]       family_code,
    output owfc_pkg::result_t     res,
    output logic                  res_valid
);

    logic [3:0]  byte_index_reg, byte_index_next;
    logic        frame_active_reg, frame_active_next;
    logic        active_type_reg, active_type_next;
    logic [7:0]  running_crc_reg, running_crc_next;
    logic [7:0]  temp_low_reg, temp_low_next;
    logic [7:0]  temp_high_reg, temp_high_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [47:0] serial_reg, serial_next;

    logic [3:0]  last_index;
    logic        crc_match;
    logic [15:0] raw_temp;

    assign last_index = (active_type_reg == owfc_pkg::FRAME_ROM) ?
                        (owfc_pkg::ROM_LEN - 4'd1) : (owfc_pkg::SCRATCH_LEN - 4'd1);
    assign crc_match  = (data_byte == running_crc_reg);
    assign raw_temp   = {temp_high_reg, temp_low_reg};

    // Frame tracking and result forming for one accepted item
    always_comb
    begin
        byte_index_next   = byte_index_reg;
        frame_active_next = frame_active_reg;
        active_type_next  = active_type_reg;
        running_crc_next  = running_crc_reg;
        temp_low_next     = temp_low_reg;
        temp_high_next    = temp_high_reg;
        first_byte_next   = first_byte_reg;
        serial_next       = serial_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (accept)
        begin
            if (kind == owfc_pkg::KIND_BUS_RESET)
            begin
                byte_index_next  = 4'd0;
                running_crc_next = 8'd0;
                if (!presence)
                begin
                    frame_active_next = 1'b0;
                    res_valid         = 1'b1;
                    res.status        = owfc_pkg::STATUS_NO_DEV;
                    res.frame_type    = frame_type;
                end
                else
                begin
                    frame_active_next = 1'b1;
                    active_type_next  = frame_type;
                end
            end
            else if (frame_active_reg)
            begin
                if (byte_index_reg != last_index)
                begin
                    // body byte: fold into CRC and capture fields
                    running_crc_next = owfc_pkg::crc8_byte(running_crc_reg, data_byte);
                    if (active_type_reg == owfc_pkg::FRAME_SCRATCH)
                    begin
                        if (byte_index_reg == 4'd0)
                        begin
                            temp_low_next = data_byte;
                        end
                        else if (byte_index_reg == 4'd1)
                        begin
                            temp_high_next = data_byte;
                        end
                    end
                    else
                    begin
                        if (byte_index_reg == 4'd0)
                        begin
                            first_byte_next = data_byte;
                        end
                        else
                        begin
                            serial_next = {data_byte, serial_reg[47:8]};
                        end
                    end
                    byte_index_next = byte_index_reg + 4'd1;
                end
                else
                begin
                    // CRC byte: close the frame and report
                    frame_active_next = 1'b0;
                    byte_index_next   = 4'd0;
                    res_valid         = 1'b1;
                    res.frame_type    = active_type_reg;
                    if (!crc_match)
                    begin
                        res.status = owfc_pkg::STATUS_CRC_ERR;
                    end
                    else if (active_type_reg == owfc_pkg::FRAME_SCRATCH)
                    begin
                        res.status      = owfc_pkg::STATUS_OK;
                        res.temperature = raw_temp & owfc_pkg::res_mask(resolution);
                    end
                    else if (first_byte_reg != family_code)
                    begin
                        res.status = owfc_pkg::STATUS_NO_DEV;
                    end
                    else
                    begin
                        res.status        = owfc_pkg::STATUS_OK;
                        res.serial_number = serial_reg;
                    end
                end
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= 4'd0;
            frame_active_reg <= 1'b0;
            active_type_reg  <= 1'b0;
            running_crc_reg  <= 8'd0;
            temp_low_reg     <= 8'd0;
            temp_high_reg    <= 8'd0;
            first_byte_reg   <= 8'd0;
            serial_reg       <= 48'd0;
        end
        else
        begin
            byte_index_reg   <= byte_index_next;
            frame_active_reg <= frame_active_next;
            active_type_reg  <= active_type_next;
            running_crc_reg  <= running_crc_next;
            temp_low_reg     <= temp_low_next;
            temp_high_reg    <= temp_high_next;
            first_byte_reg   <= first_byte_next;
            serial_reg       <= serial_next;
        end
    end

`ifndef ASSERT_OFF
    a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_active_reg |-> (byte_index_reg == 4'd0))
        else $error("byte index nonzero outside a frame");

    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        frame_active_reg |-> (byte_index_reg <= last_index))
        else $error("byte index past end of frame");

    a_scratch_no_serial: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.frame_type == owfc_pkg::FRAME_SCRATCH) |-> (res.serial_number == 48'd0))
        else $error("scratchpad result carries a serial number");

    a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !frame_active_reg)
        else $error("frame still open after a result");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/owfc_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module owfc_out_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire owfc_pkg::result_t res,
    input  wire logic              res_valid,
    input  wire logic              out_stall,
    output logic                   in_stall,
    output logic                   out_valid,
    output owfc_pkg::result_t      out_res
);

    owfc_pkg::result_t out_reg, out_next;
    owfc_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // Output register with one-deep skid buffer
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a request while output is empty");

    a_no_result_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !res_valid)
        else $error("result formed while input is stalled");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid request not moved to output");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/onewire_sensor_frame_checker_top.sv
// A result is formed combinationally from its item and registered in the output register
// or, while the output stalls, in the skid buffer. Throughput: one item per cycle while
// in_stall is low; bytewise CRC-8 update and field capture feed the frame state registers.
// Output stall: one more result fits in a skid buffer; input stalls only while it is full.
// Reset (rst_n, async, active low) clears frame state, empties the output, and loads
// resolution 12 bit and family code 40.
`timescale 1ns / 1ps
`default_nettype none

module onewire_sensor_frame_checker_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic               presence,
    input  wire logic               frame_type,
    input  wire logic [7:0]         data_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic                    result_frame_type,
    output logic signed [15:0]      temperature,
    output logic [47:0]             serial_number
);

    logic [1:0]        resolution_reg;
    logic [7:0]        family_code_reg;
    logic              accept;
    logic              res_valid;
    owfc_pkg::result_t res;
    owfc_pkg::result_t out_res;

    assign accept = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg  <= owfc_pkg::RESOLUTION_RESET;
            family_code_reg <= owfc_pkg::FAMILY_CODE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                owfc_pkg::CFG_RESOLUTION:  resolution_reg  <= cfg_data[1:0];
                owfc_pkg::CFG_FAMILY_CODE: family_code_reg <= cfg_data;
                default:                   resolution_reg  <= resolution_reg;
            endcase
        end
    end

    owfc_frame_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (kind),
        .presence    (presence),
        .frame_type  (frame_type),
        .data_byte   (data_byte),
        .resolution  (resolution_reg),
        .family_code (family_code_reg),
        .res         (res),
        .res_valid   (res_valid)
    );

    owfc_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (res_valid),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign status            = out_res.status;
    assign result_frame_type = out_res.frame_type;
    assign temperature       = out_res.temperature;
    assign serial_number     = out_res.serial_number;

endmodule

`default_nettype wire
